// ===== rtl/ultrasonic_echo_ranger_defines.svh =====
// Assertion macros used by the uer_sva checker.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UER_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uer check failed");

// Next-cycle implication, disabled during reset.
`define UER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("uer check failed");

`endif

// ===== rtl/uer_pkg.sv =====
package uer_pkg;

    localparam int CAPTURE_BITS_DEF = 16;

    localparam int CAP_W   = 16;
    localparam int MS_W    = 16;
    localparam int RANGE_W = 10;
    localparam int DIST_W  = 14;
    localparam int PULSE_W = 16;

    localparam int DIST_MUL   = 557;
    localparam int DIST_SHIFT = 11;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 8'd3;

    localparam logic [MS_W-1:0]    INTERVAL_RST  = 16'd100;
    localparam logic [MS_W-1:0]    TIMEOUT_RST   = 16'd50;
    localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 10'd2;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 10'd400;

    localparam logic [MS_W-1:0] MS_SAT = 16'hFFFF;

    // output tdata layout
    localparam int O_TRIG     = 0;
    localparam int O_RISE     = 1;
    localparam int O_PULSE_LO = 2;
    localparam int O_DIST_LO  = O_PULSE_LO + PULSE_W;
    localparam int O_DONE     = O_DIST_LO + DIST_W;
    localparam int O_TOUT     = O_DONE + 1;
    localparam int O_USED_W   = O_TOUT + 1;
    localparam int O_TDATA_W  = ((O_USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic [MS_W-1:0]    interval_ms;
        logic [MS_W-1:0]    timeout_ms;
        logic [RANGE_W-1:0] min_range_cm;
        logic [RANGE_W-1:0] max_range_cm;
    } t_cfg;

    typedef struct packed {
        logic               trigger_pulse;
        logic               edge_rising;
        logic [PULSE_W-1:0] pulse_ticks;
        logic [DIST_W-1:0]  distance_sixteenths;
        logic               meas_complete;
        logic               timed_out;
    } t_result;

endpackage

// ===== rtl/uer_cfg.sv =====
module uer_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_data,
    output uer_pkg::t_cfg                  o_cfg
);
    import uer_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                REG_INTERVAL:  n_cfg.interval_ms  = i_data[MS_W-1:0];
                REG_TIMEOUT:   n_cfg.timeout_ms   = i_data[MS_W-1:0];
                REG_MIN_RANGE: n_cfg.min_range_cm = i_data[RANGE_W-1:0];
                REG_MAX_RANGE: n_cfg.max_range_cm = i_data[RANGE_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval_ms  <= INTERVAL_RST;
            r_cfg.timeout_ms   <= TIMEOUT_RST;
            r_cfg.min_range_cm <= MIN_RANGE_RST;
            r_cfg.max_range_cm <= MAX_RANGE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/uer_core.sv =====
module uer_core #(
    parameter int CAPTURE_BITS = uer_pkg::CAPTURE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_kind,
    input  logic [uer_pkg::CAP_W-1:0] i_cap,
    input  uer_pkg::t_cfg             i_cfg,
    output uer_pkg::t_result          o_res
);
    import uer_pkg::*;

    localparam int CW = CAPTURE_BITS;
    localparam int PW = CW + 10;

    logic               r_awaiting_falling;
    logic [CW-1:0]      r_start;
    logic [PULSE_W-1:0] r_pulse;
    logic [DIST_W-1:0]  r_dist;
    logic               r_done;
    logic               r_tout;
    logic [MS_W-1:0]    r_ms;

    logic               n_awaiting_falling;
    logic [CW-1:0]      n_start;
    logic [PULSE_W-1:0] n_pulse;
    logic [DIST_W-1:0]  n_dist;
    logic               n_done;
    logic               n_tout;
    logic [MS_W-1:0]    n_ms;

    logic [31:0]        w_cap32;
    logic [CW-1:0]      w_cap;
    logic [CW-1:0]      w_width;
    logic [31:0]        w_width32;
    logic [PW-1:0]      w_prod;
    logic [PW-1:0]      w_dist;
    logic [PW-1:0]      w_min;
    logic [PW-1:0]      w_max;
    logic [DIST_W-1:0]  w_dist_ok;
    logic [MS_W-1:0]    w_ms_inc;
    logic               w_trig;
    logic               w_rising;

    assign w_cap32   = {16'd0, i_cap};
    assign w_cap     = w_cap32[CW-1:0];
    assign w_width   = w_cap - r_start;
    assign w_width32 = 32'(w_width);
    assign w_prod    = PW'(w_width) * PW'(DIST_MUL);
    assign w_dist    = w_prod >> DIST_SHIFT;
    assign w_min     = PW'({i_cfg.min_range_cm, 4'b0000});
    assign w_max     = PW'({i_cfg.max_range_cm, 4'b0000});
    assign w_dist_ok = ((w_dist < w_min) || (w_dist > w_max)) ? '0 : w_dist[DIST_W-1:0];
    assign w_ms_inc  = (r_ms != MS_SAT) ? r_ms + 16'd1 : r_ms;

    always_comb begin
        n_awaiting_falling = r_awaiting_falling;
        n_start            = r_start;
        n_pulse            = r_pulse;
        n_dist             = r_dist;
        n_done             = r_done;
        n_tout             = r_tout;
        n_ms               = r_ms;
        w_trig             = 1'b0;
        w_rising           = 1'b0;
        if (!i_kind) begin
            n_ms = w_ms_inc;
            if (w_ms_inc >= i_cfg.interval_ms) begin
                w_trig  = 1'b1;
                n_done  = 1'b0;
                n_tout  = 1'b0;
                n_start = '0;
                n_ms    = '0;
            end else if (!r_done && (w_ms_inc > i_cfg.timeout_ms)) begin
                n_tout = 1'b1;
                n_done = 1'b1;
                n_dist = '0;
            end
        end else if (!r_awaiting_falling) begin
            n_start            = w_cap;
            n_awaiting_falling = 1'b1;
            w_rising           = 1'b1;
        end else begin
            n_awaiting_falling = 1'b0;
            n_pulse            = w_width32[PULSE_W-1:0];
            n_dist             = w_dist_ok;
            n_done             = 1'b1;
            n_tout             = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting_falling <= 1'b0;
            r_start            <= '0;
            r_pulse            <= '0;
            r_dist             <= '0;
            r_done             <= 1'b0;
            r_tout             <= 1'b0;
            r_ms               <= '0;
        end else if (i_en) begin
            r_awaiting_falling <= n_awaiting_falling;
            r_start            <= n_start;
            r_pulse            <= n_pulse;
            r_dist             <= n_dist;
            r_done             <= n_done;
            r_tout             <= n_tout;
            r_ms               <= n_ms;
        end
    end

    always_comb begin
        o_res.trigger_pulse       = w_trig;
        o_res.edge_rising         = w_rising;
        o_res.pulse_ticks         = n_pulse;
        o_res.distance_sixteenths = n_dist;
        o_res.meas_complete       = n_done;
        o_res.timed_out           = n_tout;
    end

endmodule

// ===== rtl/ultrasonic_echo_ranger.sv =====
// A request accepted on s_axis reaches m_axis through the input register, then
// the result register. Throughput: one request per cycle unless m_axis stalls;
// each request updates the ranging state in a single pass through the 557x width
// multiply and the range compares.
// Reset: i_rst_n is synchronous, active low; it restores register defaults and
// clears the ranging state and both pipeline stages.
module ultrasonic_echo_ranger #(
    parameter int CAPTURE_BITS = uer_pkg::CAPTURE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [uer_pkg::CAP_W-1:0]      s_axis_tdata,  // capture_value
    input  logic                           s_axis_tuser,  // kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // trigger_pulse, edge_rising, pulse_ticks[15:0], distance_sixteenths[13:0],
    // meas_complete, timed_out, zero pad
    output logic [uer_pkg::O_TDATA_W-1:0]  m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import uer_pkg::*;

    logic               r_in_valid;
    logic               r_in_kind;
    logic [CAP_W-1:0]   r_in_cap;
    logic               r_out_valid;
    logic [O_TDATA_W-1:0] r_out_data;

    logic    w_in_take;
    logic    w_adv;
    t_cfg    w_cfg;
    t_result w_res;

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    uer_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    uer_core #(
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_kind  (r_in_kind),
        .i_cap   (r_in_cap),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind <= s_axis_tuser;
            r_in_cap  <= s_axis_tdata;
        end
        if (w_adv) begin
            r_out_data <= O_TDATA_W'({w_res.timed_out, w_res.meas_complete,
                                      w_res.distance_sixteenths, w_res.pulse_ticks,
                                      w_res.edge_rising, w_res.trigger_pulse});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/uer_sva.sv =====
`include "ultrasonic_echo_ranger_defines.svh"

module uer_sva (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [uer_pkg::O_TDATA_W-1:0]  m_axis_tdata
);
    import uer_pkg::*;

    // stalled result holds
    `UER_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // input only backs up behind a stalled result
    `UER_ASSERT_NOW(a_in_backpressure, i_clk, i_rst_n, s_axis_tvalid && !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // a trigger starts a fresh measurement
    `UER_ASSERT_NOW(a_trig_clears, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[O_TRIG], !m_axis_tdata[O_DONE] && !m_axis_tdata[O_TOUT] && !m_axis_tdata[O_RISE])

    // timeout ends the measurement with no distance
    `UER_ASSERT_NOW(a_tout_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[O_TOUT], m_axis_tdata[O_DONE] && (m_axis_tdata[O_DIST_LO +: DIST_W] == '0))

    // pad bits stay zero
    `UER_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[O_TDATA_W-1:O_USED_W] == '0)

endmodule

bind ultrasonic_echo_ranger uer_sva u_sva (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/ultrasonic_echo_ranger_checker.sv =====
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    input  logic                           i_req_is_echo,
    input  logic [uer_pkg::CAP_W-1:0]      i_req_capture,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [uer_pkg::O_TDATA_W-1:0]  i_res_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_triggers,
    output int                             o_timeouts
);
    import uer_pkg::*;

    t_cfg               ranging_cfg;
    logic               awaiting_fall;
    logic [CAP_W-1:0]   rise_capture;
    logic [PULSE_W-1:0] pulse_width_q;
    logic [DIST_W:0]    distance_q;
    logic               done_q;
    logic               timeout_q;
    logic [MS_W-1:0]    ms_elapsed;
    t_result            expected_ranges[$];
    int                 fails;
    int                 checked;
    int                 triggers;
    int                 timeouts;

    function automatic t_result range_step(input logic is_echo, input logic [CAP_W-1:0] cap);
        t_result          r;
        logic [CAP_W-1:0] pulse_len;
        logic [31:0]      range_est;
        r = '0;
        if (!is_echo) begin
            if (ms_elapsed != MS_SAT) ms_elapsed = ms_elapsed + 16'd1;
            if (ms_elapsed >= ranging_cfg.interval_ms) begin
                r.trigger_pulse = 1'b1;
                done_q = 1'b0;
                timeout_q = 1'b0;
                rise_capture = '0;
                ms_elapsed = '0;
                triggers++;
            end else if (!done_q && ms_elapsed > ranging_cfg.timeout_ms) begin
                timeout_q = 1'b1;
                done_q = 1'b1;
                distance_q = '0;
                timeouts++;
            end
        end else if (!awaiting_fall) begin
            rise_capture = cap;
            awaiting_fall = 1'b1;
            r.edge_rising = 1'b1;
        end else begin
            pulse_len = cap - rise_capture;
            range_est = (32'(pulse_len) * DIST_MUL) >> DIST_SHIFT;
            if (range_est < 32'(ranging_cfg.min_range_cm) * 16 ||
                range_est > 32'(ranging_cfg.max_range_cm) * 16)
                range_est = '0;
            awaiting_fall = 1'b0;
            pulse_width_q = pulse_len;
            distance_q = range_est[DIST_W:0];
            done_q = 1'b1;
            timeout_q = 1'b0;
        end
        r.pulse_ticks = pulse_width_q;
        r.distance_sixteenths = distance_q[DIST_W-1:0];
        r.meas_complete = done_q;
        r.timed_out = timeout_q;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (!i_rst_n) begin
            ranging_cfg = '{INTERVAL_RST, TIMEOUT_RST, MIN_RANGE_RST, MAX_RANGE_RST};
            awaiting_fall = 1'b0;
            rise_capture = '0;
            pulse_width_q = '0;
            distance_q = '0;
            done_q = 1'b0;
            timeout_q = 1'b0;
            ms_elapsed = '0;
            expected_ranges.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_INTERVAL:  ranging_cfg.interval_ms = i_cfg_data[MS_W-1:0];
                    REG_TIMEOUT:   ranging_cfg.timeout_ms = i_cfg_data[MS_W-1:0];
                    REG_MIN_RANGE: ranging_cfg.min_range_cm = i_cfg_data[RANGE_W-1:0];
                    REG_MAX_RANGE: ranging_cfg.max_range_cm = i_cfg_data[RANGE_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_ranges.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected, actual %h", $time, i_res_data);
                end else begin
                    want = expected_ranges.pop_front();
                    check_field("trigger_pulse", 32'(want.trigger_pulse),
                                32'(i_res_data[O_TRIG]));
                    check_field("edge_rising", 32'(want.edge_rising),
                                32'(i_res_data[O_RISE]));
                    check_field("pulse_ticks", 32'(want.pulse_ticks),
                                32'(i_res_data[O_PULSE_LO +: PULSE_W]));
                    check_field("distance_sixteenths", 32'(want.distance_sixteenths),
                                32'(i_res_data[O_DIST_LO +: DIST_W]));
                    check_field("meas_complete", 32'(want.meas_complete),
                                32'(i_res_data[O_DONE]));
                    check_field("timed_out", 32'(want.timed_out),
                                32'(i_res_data[O_TOUT]));
                    checked++;
                end
            end
            if (i_req_valid && i_req_ready)
                expected_ranges.push_back(range_step(i_req_is_echo, i_req_capture));
        end
        o_fail_count <= fails;
        o_pending <= expected_ranges.size();
        o_checked <= checked;
        o_triggers <= triggers;
        o_timeouts <= timeouts;
    end

endmodule

// ===== bench/tb_ultrasonic_echo_ranger.sv =====
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;
    import uer_pkg::*;

    localparam logic                 EV_TICK      = 1'b0;
    localparam logic                 EV_ECHO      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;
    localparam int                   QUIET_LIMIT  = 2000;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CAP_W-1:0]      s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [O_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int requests_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    int fail_count;
    int pending;
    int checked;
    int triggers;
    int timeouts;

    ultrasonic_echo_ranger uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ultrasonic_echo_ranger_checker ranging_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_is_echo (s_axis_tuser),
        .i_req_capture (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_triggers    (triggers),
        .o_timeouts    (timeouts)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_event(input logic kind, input logic [CAP_W-1:0] cap);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= cap;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input logic [MS_W-1:0] interval, input logic [MS_W-1:0] timeout,
                                  input logic [RANGE_W-1:0] min_cm,
                                  input logic [RANGE_W-1:0] max_cm);
        write_reg(REG_INTERVAL, interval);
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_MIN_RANGE, {6'($urandom), min_cm});
        write_reg(REG_MAX_RANGE, {6'($urandom), max_cm});
        write_reg(REG_UNMAPPED, 16'($urandom));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // drop valid, then wait for every outstanding result plus pipeline slack
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [CAP_W-1:0]   echo_base;
        logic [CAP_W-1:0]   pulse_len;
        logic [MS_W-1:0]    interval;
        logic [MS_W-1:0]    timeout;
        logic [RANGE_W-1:0] min_cm;
        logic [RANGE_W-1:0] max_cm;
        int                 target;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults
        send_event(EV_TICK, 16'hFFFF);
        send_event(EV_ECHO, 16'hFFF0);
        send_event(EV_ECHO, 16'h0010);  // counter wrap, below min
        send_event(EV_ECHO, 16'h1000);
        send_event(EV_ECHO, 16'h13E8);
        send_event(EV_ECHO, 16'h0000);
        send_event(EV_ECHO, 16'hFFFF);  // widest pulse, above max
        send_event(EV_ECHO, 16'h5555);
        send_event(EV_ECHO, 16'h5555);
        send_event(EV_ECHO, 16'hAAAA);
        send_event(EV_ECHO, 16'hAAAA + 16'd23533);  // lands on max range exactly

        // zero interval: trigger between edges clears the start capture
        settle();
        apply_settings(16'd0, 16'd0, 10'd0, 10'h3FF);
        send_event(EV_TICK, 16'h0000);
        send_event(EV_ECHO, 16'h0100);
        send_event(EV_TICK, 16'h0000);
        send_event(EV_ECHO, 16'hFFFF);

        // zero timeout
        settle();
        apply_settings(16'd3, 16'd0, 10'd2, 10'd400);
        repeat (4) send_event(EV_TICK, 16'($urandom));
        send_event(EV_ECHO, 16'h2000);
        send_event(EV_ECHO, 16'h2000 + 16'd2000);

        // min above max
        settle();
        apply_settings(16'hFFFF, 16'hFFFF, 10'h3FF, 10'd0);
        send_event(EV_ECHO, 16'h0000);
        send_event(EV_ECHO, 16'd1000);

        for (int phase = 0; phase < 8; phase++) begin
            interval = 16'($urandom_range(2, 24));
            timeout = 16'($urandom_range(0, 20));
            min_cm = 10'($urandom_range(0, 40));
            max_cm = 10'($urandom_range(100, 1023));
            if (phase == 0) begin
                interval = 16'd1;
                timeout = 16'd0;
            end else if (phase == 5) begin
                interval = 16'hFFFF;
                timeout = 16'hFFFF;
                min_cm = 10'd0;
                max_cm = 10'h3FF;
            end else if (phase == 6) begin
                min_cm = 10'd600;
                max_cm = 10'd300;
            end
            settle();
            apply_settings(interval, timeout, min_cm, max_cm);
            idle_pct = (phase % 4 == 1) ? 67 : (phase % 4 == 3) ? 25 : 0;
            stall_pct = (phase % 4 == 2) ? 67 : (phase % 4 == 3) ? 25 : 0;
            target = requests_sent + 50;
            while (requests_sent < target) begin
                case ($urandom_range(9))
                    0, 1: repeat ($urandom_range(1, 12)) send_event(EV_TICK, 16'($urandom));
                    2: send_event(EV_ECHO, 16'($urandom));
                    default: begin
                        repeat ($urandom_range(0, 8)) send_event(EV_TICK, 16'($urandom));
                        echo_base = 16'($urandom);
                        case ($urandom_range(3))
                            0: pulse_len = 16'($urandom_range(0, 3000));
                            1, 2: pulse_len = 16'($urandom_range(0, 60200));
                            default: pulse_len = 16'($urandom);
                        endcase
                        send_event(EV_ECHO, echo_base);
                        repeat ($urandom_range(0, 2)) send_event(EV_TICK, 16'($urandom));
                        send_event(EV_ECHO, echo_base + pulse_len);
                    end
                endcase
            end
        end

        settle();
        $display("ran %0d requests over %0d register settings and four idle patterns",
                 requests_sent, settings_used);
        $display("compared %0d results, including %0d triggers and %0d timeouts",
                 checked, triggers, timeouts);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
